// ===== hw/rtl/fplt_pkg.sv =====
// Shared types, codes and constants of the port login table.
`timescale 1ns / 1ps

package fplt_pkg;

	localparam int MAC_W    = 48;
	localparam int PID_W    = 24;
	localparam int INTF_W   = 4;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;

	localparam int DEF_PORT_SLOTS      = 32;
	localparam int DEF_INTERFACE_COUNT = 16;

	localparam logic [PID_W-1:0] FC_MAP_RESET  = 24'h0EFC00;
	localparam logic [PID_W-1:0] BASE_ID_RESET = 24'h18AE00;

	// Request codes
	localparam logic [FUNC_W-1:0] FN_ADD         = 3'd0;
	localparam logic [FUNC_W-1:0] FN_FIND_LOGIN  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_FIND_PHYS   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_FIND_ID     = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE_ID   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REMOVE_INTF = 3'd5;

	// Register indexes
	localparam logic [1:0] REG_FC_MAP  = 2'd0;
	localparam logic [1:0] REG_SPMA    = 2'd1;
	localparam logic [1:0] REG_BASE_ID = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_NO_FREE   = 2'd2,
		STAT_SPMA_OFF  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CO_IDLE,
		CO_EVICT,
		CO_FIND_LOGIN,
		CO_FIND_PHYS,
		CO_FIND_ID,
		CO_ALLOC,
		CO_DROP_INTF
	} cell_op_t;

	// One slot's view, as it travels along the chain
	typedef struct packed {
		logic [PID_W-1:0]  port_id;
		logic [MAC_W-1:0]  login_mac;
		logic [MAC_W-1:0]  physical_mac;
		logic [INTF_W-1:0] intf;
	} entry_t;

	// Command broadcast to every cell
	typedef struct packed {
		cell_op_t          op;
		logic              free_sel;
		logic              write_en;
		logic              given;
		logic [MAC_W-1:0]  login_mac;
		logic [MAC_W-1:0]  physical_mac;
		logic [PID_W-1:0]  port_id;
		logic [INTF_W-1:0] intf;
		logic [PID_W-1:0]  fc_map;
		logic [PID_W-1:0]  base_id;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/fplt_cell.sv =====
// One table slot: holds its entry, compares it and joins the priority chain.
`timescale 1ns / 1ps

module fplt_cell
	import fplt_pkg::*;
#(
	parameter int SLOT_INDEX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  logic      prior_in,
	output logic      prior_out,
	input  entry_t    bus_in,
	output entry_t    bus_out,
	output logic      sel
);

	logic              used_q;
	logic [MAC_W-1:0]  login_mac_q;
	logic [MAC_W-1:0]  physical_mac_q;
	logic [INTF_W-1:0] intf_q;

	logic [PID_W-1:0]  slot_id;
	logic [MAC_W-1:0]  new_login_mac;
	logic              cand;
	logic              evict;
	logic              drop;
	logic              alloc_wr;
	entry_t            view;

	assign slot_id = {cmd.base_id[PID_W-1:8], cmd.base_id[7:0] + 8'(SLOT_INDEX + 1)};
	assign new_login_mac = cmd.given ? cmd.login_mac : {cmd.fc_map, slot_id};

	always_comb begin
		case (cmd.op)
			CO_FIND_LOGIN: cand = used_q && (login_mac_q == cmd.login_mac);
			CO_FIND_PHYS:  cand = used_q && (physical_mac_q == cmd.physical_mac);
			CO_FIND_ID:    cand = used_q && (slot_id == cmd.port_id);
			CO_ALLOC:      cand = !used_q;
			default:       cand = 1'b0;
		endcase
	end

	// lowest candidate wins: an earlier winner blocks the rest of the chain
	assign sel       = cand && !prior_in;
	assign prior_out = prior_in || cand;

	always_comb begin
		if (cmd.op == CO_ALLOC) begin
			view = '{port_id: slot_id, login_mac: new_login_mac,
				physical_mac: cmd.physical_mac, intf: cmd.intf};
		end else begin
			view = '{port_id: slot_id, login_mac: login_mac_q,
				physical_mac: physical_mac_q, intf: intf_q};
		end
	end

	assign bus_out = entry_t'(bus_in | (sel ? view : entry_t'('0)));

	assign evict = (cmd.op == CO_EVICT) && used_q &&
		((physical_mac_q == cmd.physical_mac) ||
		 (cmd.given && (login_mac_q == cmd.login_mac)));
	assign drop = ((cmd.op == CO_DROP_INTF) && used_q && (intf_q == cmd.intf)) ||
		((cmd.op == CO_FIND_ID) && sel && cmd.free_sel);
	assign alloc_wr = (cmd.op == CO_ALLOC) && sel && cmd.write_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (alloc_wr) begin
			used_q <= 1'b1;
		end else if (evict || drop) begin
			used_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_wr) begin
			login_mac_q    <= new_login_mac;
			physical_mac_q <= cmd.physical_mac;
			intf_q         <= cmd.intf;
		end
	end

endmodule

// ===== hw/rtl/fplt_apb_regs.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module fplt_apb_regs
	import fplt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [PID_W-1:0] fc_map,
	output logic             spma_allowed,
	output logic [PID_W-1:0] base_id
);

	logic [PID_W-1:0] fc_map_q;
	logic             spma_q;
	logic [PID_W-1:0] base_id_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_map_q  <= FC_MAP_RESET;
			spma_q    <= 1'b0;
			base_id_q <= BASE_ID_RESET;
		end else if (wr) begin
			case (paddr[3:2])
				REG_FC_MAP:  fc_map_q  <= pwdata[PID_W-1:0];
				REG_SPMA:    spma_q    <= pwdata[0];
				REG_BASE_ID: base_id_q <= pwdata[PID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FC_MAP:  prdata = {8'd0, fc_map_q};
			REG_SPMA:    prdata = {31'd0, spma_q};
			REG_BASE_ID: prdata = {8'd0, base_id_q};
			default:     prdata = '0;
		endcase
	end

	assign fc_map       = fc_map_q;
	assign spma_allowed = spma_q;
	assign base_id      = base_id_q;

endmodule

// ===== hw/rtl/fcoe_port_login_table.sv =====
// Port login table top level: request sequencer, slot chain and output register.
`timescale 1ns / 1ps

// FCoE port login table with PORT_SLOTS slots, slot i owning port ID
// {base[23:8], base[7:0]+i+1}. One request is worked at a time: an add
// with a valid interface steps through accept, evict matching entries,
// allocate the lowest free slot and load the output register; finds,
// removes, unknown codes and adds with an out-of-range interface have
// no allocate step and load the output register after their first step.
// Each step is one pass over the row of slot cells, which compare in parallel
// and pick the lowest match through a priority chain running from slot 0
// upward. A new request is taken once the previous result has moved into the
// output register, so it may stand while that result still waits for
// m_axis_tready; a result that cannot move holds the sequencer for as long as
// m_axis_tready stays low. Configuration registers sit at byte addresses
// 0 (FC-MAP), 4 (server MAC allowed) and 8 (base port ID) and may be written
// only while the table is idle.
module fcoe_port_login_table
	import fplt_pkg::*;
#(
	parameter int PORT_SLOTS      = DEF_PORT_SLOTS,
	parameter int INTERFACE_COUNT = DEF_INTERFACE_COUNT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// physical_mac[47:0], login_mac[95:48], lookup_port_id[119:96],
	// interface_number[123:120], zero [127:124]
	input  logic [127:0]  s_axis_tdata,
	// func[2:0], login_mac_given[3]
	input  logic [3:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// status[1:0], result_port_id[25:2], result_login_mac[73:26],
	// result_physical_mac[121:74], result_interface[125:122], zero [127:126]
	output logic [127:0]  m_axis_tdata,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_ALLOC,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [FUNC_W-1:0] req_func_q;
	logic              req_given_q;
	logic [MAC_W-1:0]  req_pmac_q;
	logic [MAC_W-1:0]  req_lmac_q;
	logic [PID_W-1:0]  req_pid_q;
	logic [INTF_W-1:0] req_intf_q;

	status_t           res_status_q;
	entry_t            res_entry_q;
	status_t           out_status_q;
	entry_t            out_entry_q;
	logic              out_valid_q;

	logic [PID_W-1:0]  fc_map;
	logic              spma_allowed;
	logic [PID_W-1:0]  base_id;

	cell_cmd_t               cmd;
	logic [PORT_SLOTS:0]     prior;
	entry_t                  bus [PORT_SLOTS+1];
	logic [PORT_SLOTS-1:0]   sel_vec;
	logic                    chain_any;
	entry_t                  chain_entry;
	logic                    in_accept;
	logic                    intf_ok;
	logic                    spma_reject;
	logic                    load_out;

	fplt_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fc_map       (fc_map),
		.spma_allowed (spma_allowed),
		.base_id      (base_id)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign intf_ok       = (int'(req_intf_q) < INTERFACE_COUNT);
	assign spma_reject   = req_given_q && !spma_allowed;
	// hold the finished result until the output register is free or being emptied
	assign load_out      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_pmac_q  <= s_axis_tdata[47:0];
			req_lmac_q  <= s_axis_tdata[95:48];
			req_pid_q   <= s_axis_tdata[119:96];
			req_intf_q  <= s_axis_tdata[123:120];
			req_func_q  <= s_axis_tuser[2:0];
			req_given_q <= s_axis_tuser[3];
		end
	end

	always_comb begin
		cmd.op           = CO_IDLE;
		cmd.free_sel     = 1'b0;
		cmd.write_en     = 1'b0;
		cmd.given        = req_given_q;
		cmd.login_mac    = req_lmac_q;
		cmd.physical_mac = req_pmac_q;
		cmd.port_id      = req_pid_q;
		cmd.intf         = req_intf_q;
		cmd.fc_map       = fc_map;
		cmd.base_id      = base_id;
		case (state_q)
			ST_FIRST: begin
				case (req_func_q)
					FN_ADD:         cmd.op = intf_ok ? CO_EVICT : CO_IDLE;
					FN_FIND_LOGIN:  cmd.op = CO_FIND_LOGIN;
					FN_FIND_PHYS:   cmd.op = CO_FIND_PHYS;
					FN_FIND_ID:     cmd.op = CO_FIND_ID;
					FN_REMOVE_ID: begin
						cmd.op       = CO_FIND_ID;
						cmd.free_sel = 1'b1;
					end
					FN_REMOVE_INTF: cmd.op = intf_ok ? CO_DROP_INTF : CO_IDLE;
					default:        cmd.op = CO_IDLE;
				endcase
			end
			ST_ALLOC: begin
				cmd.op       = CO_ALLOC;
				cmd.write_en = !spma_reject;
			end
			default: ;
		endcase
	end

	assign prior[0] = 1'b0;
	assign bus[0]   = entry_t'('0);

	for (genvar g = 0; g < PORT_SLOTS; g++) begin : g_slot
		fplt_cell #(
			.SLOT_INDEX (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prior_in  (prior[g]),
			.prior_out (prior[g+1]),
			.bus_in    (bus[g]),
			.bus_out   (bus[g+1]),
			.sel       (sel_vec[g])
		);
	end

	assign chain_any   = prior[PORT_SLOTS];
	assign chain_entry = bus[PORT_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			res_status_q <= STAT_NOT_FOUND;
			res_entry_q  <= '0;
			out_status_q <= STAT_NOT_FOUND;
			out_entry_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					if (req_func_q == FN_ADD && intf_ok) begin
						state_q <= ST_ALLOC;
					end else begin
						state_q <= ST_DONE;
						if ((req_func_q inside {FN_FIND_LOGIN, FN_FIND_PHYS,
								FN_FIND_ID, FN_REMOVE_ID}) && chain_any) begin
							res_status_q <= STAT_OK;
							res_entry_q  <= chain_entry;
						end else if (req_func_q == FN_REMOVE_INTF && intf_ok) begin
							res_status_q <= STAT_OK;
							res_entry_q  <= '0;
						end else begin
							res_status_q <= STAT_NOT_FOUND;
							res_entry_q  <= '0;
						end
					end
				end
				ST_ALLOC: begin
					if (!chain_any) begin
						res_status_q <= STAT_NO_FREE;
						res_entry_q  <= '0;
					end else if (spma_reject) begin
						res_status_q <= STAT_SPMA_OFF;
						res_entry_q  <= '0;
					end else begin
						res_status_q <= STAT_OK;
						res_entry_q  <= chain_entry;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						out_status_q <= res_status_q;
						out_entry_q  <= res_entry_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_entry_q.intf, out_entry_q.physical_mac,
		out_entry_q.login_mac, out_entry_q.port_id, out_status_q};

`ifndef SYNTHESIS
	a_single_winner: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec))
		else $error("more than one slot selected on the chain");

	a_full_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC && !chain_any) |=> (res_status_q == STAT_NO_FREE))
		else $error("allocation without free slot not reported");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result presented outside the completion step");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the port login table: streamed requests, predicted replies.
`timescale 1ns / 1ps

module testbench;
	import fplt_pkg::*;

	localparam int TABLE_SLOTS = DEF_PORT_SLOTS;
	localparam int INTF_LIMIT  = DEF_INTERFACE_COUNT;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [MAC_W-1:0]  pmac;
		logic [MAC_W-1:0]  lmac;
		logic              given;
		logic [PID_W-1:0]  pid;
		logic [INTF_W-1:0] intf;
	} login_request_t;

	typedef struct packed {
		status_t           status;
		logic [PID_W-1:0]  pid;
		logic [MAC_W-1:0]  lmac;
		logic [MAC_W-1:0]  pmac;
		logic [INTF_W-1:0] intf;
	} login_reply_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [127:0]  s_axis_tdata = '0;
	logic [3:0]    s_axis_tuser = '0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [127:0]  m_axis_tdata;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [3:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;

	fcoe_port_login_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	// Register copies and table contents as the predictor sees them
	logic [PID_W-1:0]       fc_map_cfg  = FC_MAP_RESET;
	logic                   spma_cfg    = 1'b0;
	logic [PID_W-1:0]       base_id_cfg = BASE_ID_RESET;
	logic [TABLE_SLOTS-1:0] slot_free   = '1;
	logic [MAC_W-1:0]       slot_login   [TABLE_SLOTS];
	logic [MAC_W-1:0]       slot_station [TABLE_SLOTS];
	logic [INTF_W-1:0]      slot_intf    [TABLE_SLOTS];

	login_request_t pending_requests[$];
	login_reply_t   expected_replies[$];
	login_request_t offered;
	int             mismatch_count = 0;

	logic [MAC_W-1:0] station_pool  [48];
	logic [MAC_W-1:0] supplied_pool [16];

	function automatic logic [PID_W-1:0] slot_port_id(int i);
		logic [7:0] low_byte;
		low_byte = base_id_cfg[7:0] + 8'(i + 1);
		return {base_id_cfg[23:8], low_byte};
	endfunction

	function automatic logic [MAC_W-1:0] fabric_mac(int i);
		return {fc_map_cfg, slot_port_id(i)};
	endfunction

	function automatic logic [MAC_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[MAC_W-1:0];
	endfunction

	// Work out the reply to one request and update the table copy
	function automatic login_reply_t predict_table_reply(login_request_t r);
		login_reply_t rsp;
		int           hit;
		logic         match;
		rsp = '0;
		rsp.status = STAT_NOT_FOUND;
		hit = -1;
		case (r.func)
			FN_ADD: begin
				if (r.intf < INTF_LIMIT) begin
					for (int i = 0; i < TABLE_SLOTS; i++)
						if (!slot_free[i] && (slot_station[i] == r.pmac ||
								(r.given && slot_login[i] == r.lmac)))
							slot_free[i] = 1'b1;
					if (slot_free == '0) begin
						rsp.status = STAT_NO_FREE;
					end else if (r.given && !spma_cfg) begin
						rsp.status = STAT_SPMA_OFF;
					end else begin
						for (int i = TABLE_SLOTS - 1; i >= 0; i--)
							if (slot_free[i])
								hit = i;
						slot_free[hit] = 1'b0;
						slot_login[hit] = r.given ? r.lmac : fabric_mac(hit);
						slot_station[hit] = r.pmac;
						slot_intf[hit] = r.intf;
						rsp.status = STAT_OK;
					end
				end
			end
			FN_FIND_LOGIN, FN_FIND_PHYS, FN_FIND_ID, FN_REMOVE_ID: begin
				// scan downward so the lowest matching slot is kept
				for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
					case (r.func)
						FN_FIND_LOGIN: match = slot_login[i] == r.lmac;
						FN_FIND_PHYS:  match = slot_station[i] == r.pmac;
						default:       match = slot_port_id(i) == r.pid;
					endcase
					if (!slot_free[i] && match)
						hit = i;
				end
				if (hit >= 0)
					rsp.status = STAT_OK;
			end
			FN_REMOVE_INTF: begin
				if (r.intf < INTF_LIMIT) begin
					for (int i = 0; i < TABLE_SLOTS; i++)
						if (!slot_free[i] && slot_intf[i] == r.intf)
							slot_free[i] = 1'b1;
					rsp.status = STAT_OK;
				end
			end
			default: ;
		endcase
		if (hit >= 0) begin
			rsp.pid  = slot_port_id(hit);
			rsp.lmac = slot_login[hit];
			rsp.pmac = slot_station[hit];
			rsp.intf = slot_intf[hit];
			if (r.func == FN_REMOVE_ID)
				slot_free[hit] = 1'b1;
		end
		return rsp;
	endfunction

	// Request driver: bursts of random length separated by random gaps
	int burst_left = 4;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_replies.push_back(predict_table_reply(offered));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0 || pending_requests.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_axis_tvalid <= 1'b0;
				end else begin
					offered = pending_requests.pop_front();
					s_axis_tdata  <= {4'b0, offered.intf, offered.pid, offered.lmac, offered.pmac};
					s_axis_tuser  <= {offered.given, offered.func};
					s_axis_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Reply receiver: stall on a rotating 32-bit pattern, replaced each time its position wraps
	logic [31:0] stall_pattern = '1;
	int          stall_pos = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= stall_pattern[stall_pos];
			stall_pos = (stall_pos + 1) % 32;
			if (stall_pos == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pattern = '1;
					1:       stall_pattern = $urandom();
					2:       stall_pattern = $urandom() | $urandom();
					default: stall_pattern = $urandom() & $urandom();
				endcase
				stall_pattern[$urandom_range(0, 31)] = 1'b1;
			end
		end
	end

	// Reply monitor
	always @(posedge clk) begin
		login_reply_t got;
		login_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = status_t'(m_axis_tdata[1:0]);
			got.pid    = m_axis_tdata[25:2];
			got.lmac   = m_axis_tdata[73:26];
			got.pmac   = m_axis_tdata[121:74];
			got.intf   = m_axis_tdata[125:122];
			if (expected_replies.size() == 0) begin
				$error("reply with none outstanding: status %0d", got.status);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				if (got.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.pid !== want.pid) begin
					$error("result_port_id expected %h got %h", want.pid, got.pid);
					mismatch_count++;
				end
				if (got.lmac !== want.lmac) begin
					$error("result_login_mac expected %h got %h", want.lmac, got.lmac);
					mismatch_count++;
				end
				if (got.pmac !== want.pmac) begin
					$error("result_physical_mac expected %h got %h", want.pmac, got.pmac);
					mismatch_count++;
				end
				if (got.intf !== want.intf) begin
					$error("result_interface expected %0d got %0d", want.intf, got.intf);
					mismatch_count++;
				end
			end
		end
	end

	function automatic login_request_t make_request(logic [FUNC_W-1:0] func,
			logic [MAC_W-1:0] pmac, logic [MAC_W-1:0] lmac, logic given,
			logic [PID_W-1:0] pid, logic [INTF_W-1:0] intf);
		login_request_t r;
		r.func = func;
		r.pmac = pmac;
		r.lmac = lmac;
		r.given = given;
		r.pid = pid;
		r.intf = intf;
		return r;
	endfunction

	function automatic logic [MAC_W-1:0] pick_login_mac();
		case ($urandom_range(0, 3))
			0:       return fabric_mac($urandom_range(0, 33));
			1:       return supplied_pool[$urandom_range(0, 15)];
			2:       return {fc_map_cfg, PID_W'($urandom())};
			default: return rand48();
		endcase
	endfunction

	function automatic login_request_t random_request(int add_pct);
		login_request_t r;
		int             roll;
		r.pmac  = station_pool[$urandom_range(0, 47)];
		r.lmac  = pick_login_mac();
		r.given = spma_cfg ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
		r.pid   = ($urandom_range(0, 4) == 0) ? PID_W'($urandom())
			: slot_port_id($urandom_range(0, 35));
		r.intf  = ($urandom_range(0, 4) == 0) ? INTF_W'($urandom_range(0, 15))
			: INTF_W'($urandom_range(0, 3));
		roll = $urandom_range(0, 99);
		if (roll < 7) begin
			// noise: every field free
			r = make_request(FUNC_W'($urandom_range(0, 7)), rand48(), rand48(),
				1'($urandom_range(0, 1)), PID_W'($urandom()), INTF_W'($urandom()));
		end else if (roll < 7 + add_pct) begin
			r.func = FN_ADD;
		end else begin
			case ($urandom_range(0, 9))
				0, 1:    r.func = FN_FIND_LOGIN;
				2, 3:    r.func = FN_FIND_PHYS;
				4, 5:    r.func = FN_FIND_ID;
				6, 7, 8: r.func = FN_REMOVE_ID;
				default: r.func = FN_REMOVE_INTF;
			endcase
		end
		return r;
	endfunction

	task automatic wait_table_idle();
		@(negedge clk);
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_FC_MAP:  fc_map_cfg  = value[PID_W-1:0];
			REG_SPMA:    spma_cfg    = value[0];
			REG_BASE_ID: base_id_cfg = value[PID_W-1:0];
			default: ;
		endcase
		// read back
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== value) begin
			$error("register %0d readback expected %h got %h", idx, value, prdata);
			mismatch_count++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random_phase(input logic [23:0] fc_map, input logic spma,
			input logic [23:0] base_id, input int count, input int add_pct);
		wait_table_idle();
		write_register(REG_FC_MAP, {8'h0, fc_map});
		write_register(REG_SPMA, {31'h0, spma});
		write_register(REG_BASE_ID, {8'h0, base_id});
		for (int i = 0; i < 16; i++)
			supplied_pool[i] = (i < 6) ? fabric_mac($urandom_range(0, 31)) : rand48();
		supplied_pool[0] = '1;
		@(negedge clk);
		for (int i = 0; i < count; i++)
			pending_requests.push_back(random_request(add_pct));
	endtask

	initial begin
		logic [MAC_W-1:0] st_a;
		logic [MAC_W-1:0] st_b;
		for (int i = 0; i < 48; i++)
			station_pool[i] = rand48();
		station_pool[0] = '0;
		station_pool[1] = '1;
		for (int i = 0; i < 16; i++)
			supplied_pool[i] = rand48();
		st_a = rand48();
		st_b = rand48();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening under reset register values
		pending_requests.push_back(make_request(FN_FIND_ID, '0, '0, 1'b0, slot_port_id(0), 4'd0));
		pending_requests.push_back(make_request(FN_ADD, '0, '1, 1'b0, '0, 4'd0));
		pending_requests.push_back(make_request(FN_ADD, '1, '0, 1'b0, '1, 4'd15));
		pending_requests.push_back(make_request(FN_ADD, '0, rand48(), 1'b0, '0, 4'd2));
		pending_requests.push_back(make_request(FN_ADD, st_a, rand48(), 1'b1, '0, 4'd1));
		// supplied MAC equal to slot 1's address: evicts it, then is refused
		pending_requests.push_back(make_request(FN_ADD, st_b, fabric_mac(1), 1'b1, '0, 4'd1));
		pending_requests.push_back(make_request(FN_FIND_LOGIN, '1, fabric_mac(0), 1'b0, '0, 4'd0));
		pending_requests.push_back(make_request(FN_FIND_LOGIN, '0, '1, 1'b1, '1, 4'd15));
		pending_requests.push_back(make_request(FN_FIND_PHYS, '0, '1, 1'b0, '0, 4'd0));
		pending_requests.push_back(make_request(FN_FIND_PHYS, '1, '0, 1'b0, '0, 4'd0));
		pending_requests.push_back(make_request(FN_FIND_ID, '1, '1, 1'b0, '0, 4'd0));
		pending_requests.push_back(make_request(FN_FIND_ID, '0, '0, 1'b0, '1, 4'd0));
		pending_requests.push_back(make_request(FN_ADD, st_a, '0, 1'b0, '0, 4'd7));
		pending_requests.push_back(make_request(FN_ADD, st_b, '0, 1'b0, '0, 4'd7));
		pending_requests.push_back(make_request(FN_REMOVE_ID, '0, '0, 1'b0, slot_port_id(1), 4'd0));
		pending_requests.push_back(make_request(FN_REMOVE_ID, '0, '0, 1'b0, slot_port_id(1), 4'd0));
		pending_requests.push_back(make_request(FN_REMOVE_INTF, '0, '0, 1'b0, '0, 4'd7));
		pending_requests.push_back(make_request(FN_REMOVE_INTF, '0, '0, 1'b0, '0, 4'd7));
		pending_requests.push_back(make_request(FN_FIND_PHYS, st_b, '0, 1'b0, '0, 4'd0));
		pending_requests.push_back(make_request(3'd6, '1, '1, 1'b1, '1, 4'd15));
		pending_requests.push_back(make_request(3'd7, rand48(), rand48(), 1'b0, '0, 4'd3));
		pending_requests.push_back(make_request(FN_REMOVE_INTF, '1, '1, 1'b1, '1, 4'd15));
		pending_requests.push_back(make_request(FN_FIND_ID, '0, '0, 1'b0, slot_port_id(0), 4'd0));
		for (int i = 0; i < 300; i++)
			pending_requests.push_back(random_request(45));

		run_random_phase(24'hFFFFFF, 1'b1, 24'hFFFFF0, 330, 45);
		run_random_phase(24'h000000, 1'b1, 24'h000000, 330, 50);
		run_random_phase(PID_W'($urandom()), 1'b0, PID_W'($urandom()), 330, 45);
		run_random_phase(PID_W'($urandom()), 1'b1, 24'hFFFFFF, 330, 55);
		// mostly adds: fill the table to exhaustion
		run_random_phase(FC_MAP_RESET, 1'b0, BASE_ID_RESET, 330, 80);

		wait_table_idle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/fplt_pkg.sv
hw/rtl/fplt_cell.sv
hw/rtl/fplt_apb_regs.sv
hw/rtl/fcoe_port_login_table.sv
dv/testbench.sv
